// File: rtl/ddo_pkg.sv
// Shared constants, types and the arctangent table for the odometry block.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 4;

    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032875;
    localparam logic [23:0]        RAD_TO_BAM_Q10  = 24'd10680707;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_RADIUS      = 4'd0,
        REG_INVERSE_WHEELBASE = 4'd1,
        REG_HEADING_SCALE     = 4'd2,
        REG_SPEED_DEADBAND    = 4'd3
    } reg_idx_t;

    typedef struct packed {
        logic               done;
        logic signed [16:0] cos_val;
        logic signed [16:0] sin_val;
    } cs_t;

    function automatic logic [29:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:    r = 30'h20000000;
            5'd1:    r = 30'h12E4051E;
            5'd2:    r = 30'h09FB385B;
            5'd3:    r = 30'h051111D4;
            5'd4:    r = 30'h028B0D43;
            5'd5:    r = 30'h0145D7E1;
            5'd6:    r = 30'h00A2F61E;
            5'd7:    r = 30'h00517C55;
            5'd8:    r = 30'h0028BE53;
            5'd9:    r = 30'h00145F2F;
            5'd10:   r = 30'h000A2F98;
            5'd11:   r = 30'h000517CC;
            5'd12:   r = 30'h00028BE6;
            5'd13:   r = 30'h000145F3;
            5'd14:   r = 30'h0000A2FA;
            5'd15:   r = 30'h0000517D;
            5'd16:   r = 30'h000028BE;
            5'd17:   r = 30'h0000145F;
            5'd18:   r = 30'h00000A30;
            5'd19:   r = 30'h00000518;
            5'd20:   r = 30'h0000028C;
            5'd21:   r = 30'h00000146;
            5'd22:   r = 30'h000000A3;
            5'd23:   r = 30'h00000051;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ddo_cordic.sv
// Iterative CORDIC rotator giving Q1.15 cosine and sine of a binary angle.
module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [31:0]  angle,
    output ddo_pkg::cs_t result
);
    import ddo_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                     busy_reg;
    logic                     fold_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [32:0]       x_reg;
    logic signed [32:0]       y_reg;
    logic signed [32:0]       z_reg;
    logic [1:0]               quad_reg;
    logic signed [16:0]       cos_reg;
    logic signed [16:0]       sin_reg;

    logic [31:0]              shifted;
    logic signed [32:0]       z_start;
    logic signed [32:0]       x_sh;
    logic signed [32:0]       y_sh;
    logic signed [32:0]       at;
    logic signed [32:0]       x_next;
    logic signed [32:0]       y_next;
    logic signed [32:0]       z_next;
    logic signed [16:0]       cc;
    logic signed [16:0]       ss;
    logic signed [16:0]       cos_next;
    logic signed [16:0]       sin_next;

    function automatic logic signed [16:0] to_q15(input logic signed [32:0] v);
        logic signed [33:0] sum;
        logic signed [18:0] r;
        logic signed [16:0] q;
        sum = {v[32], v} + 34'sd16384;
        r   = sum[33:15];
        if (r > 19'sd32767)
            q = 17'sd32767;
        else if (r < -19'sd32768)
            q = -17'sd32768;
        else
            q = r[16:0];
        return q;
    endfunction

    assign shifted = angle + 32'h2000_0000;
    assign z_start = $signed({3'b000, shifted[29:0]}) - 33'sd536870912;
    assign x_sh    = x_reg >>> cnt_reg;
    assign y_sh    = y_reg >>> cnt_reg;
    assign at      = $signed({3'b000, atan_bam(ATAN_IDX_W'(cnt_reg))});

    always_comb
    begin
        if (!z_reg[32])
        begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + at;
        end
    end

    assign cc = to_q15(x_reg);
    assign ss = to_q15(y_reg);

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cos_next = cc;
                sin_next = ss;
            end
            2'd1:
            begin
                cos_next = -ss;
                sin_next = cc;
            end
            2'd2:
            begin
                cos_next = -cc;
                sin_next = -ss;
            end
            default:
            begin
                cos_next = ss;
                sin_next = -cc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fold_reg;
            fold_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fold_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= z_start;
            quad_reg <= shifted[31:30];
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fold_reg)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign result.done    = done_reg;
    assign result.cos_val = cos_reg;
    assign result.sin_val = sin_reg;

endmodule

// File: rtl/differential_drive_odometry.sv
// Differential-drive odometry: pose and velocity integration per wheel-speed transaction.
// A transaction runs the CORDIC rotation loop, then 13 operations through one shared 33x33
// multiplier, each passing through an ST_MUL and an ST_WB state, then loads the output register
// from ST_DONE. No new transaction is taken until the last one has loaded its result.
// A finished result waits in the output register while the next transaction is taken.
// Reset clears pose and heading and loads the default register values.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [15:0]           left_wheel_speed,
    input  logic signed [15:0]           right_wheel_speed,
    input  logic [15:0]                  elapsed_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           x_position,
    output logic signed [31:0]           y_position,
    output logic [15:0]                  heading_angle,
    output logic signed [31:0]           vel_x,
    output logic signed [31:0]           vel_y,
    output logic signed [31:0]           turn_rate,
    input  logic                         cfg_write_en,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]    cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CORDIC = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_WB     = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        OP_LEFT_WR,
        OP_RIGHT_WR,
        OP_DIFF_IB,
        OP_HS_DT,
        OP_W_HSDT,
        OP_RADH_K,
        OP_RADL_K,
        OP_V_C,
        OP_V_S,
        OP_C_DT,
        OP_V_CDT,
        OP_S_DT,
        OP_V_SDT
    } op_t;

    state_t              state_reg, state_next;
    op_t                 op_reg;

    logic [15:0]         wheel_radius_reg;
    logic [15:0]         inverse_wheelbase_reg;
    logic [15:0]         heading_scale_reg;
    logic [15:0]         speed_deadband_reg;

    logic [31:0]         pos_x_reg;
    logic [31:0]         pos_y_reg;
    logic [31:0]         heading_acc_reg;

    logic signed [15:0]  left_reg;
    logic signed [15:0]  right_reg;
    logic [15:0]         dt_reg;
    logic signed [24:0]  vl_reg;
    logic signed [24:0]  v_reg;
    logic signed [25:0]  diff_reg;
    logic signed [31:0]  w_reg;
    logic [31:0]         hsdt_reg;
    logic signed [38:0]  rad_reg;
    logic [25:0]         bamh_reg;
    logic signed [25:0]  vx_reg;
    logic signed [25:0]  vy_reg;
    logic signed [32:0]  tdt_reg;
    logic signed [65:0]  prod_reg;

    logic                out_valid_reg;
    logic signed [31:0]  x_position_reg;
    logic signed [31:0]  y_position_reg;
    logic [15:0]         heading_angle_reg;
    logic signed [31:0]  vel_x_reg;
    logic signed [31:0]  vel_y_reg;
    logic signed [31:0]  turn_rate_reg;

    logic                in_accept;
    logic                out_load;
    cs_t                 cs;

    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;

    logic signed [24:0]  prod_q8;
    logic signed [25:0]  vsum;
    logic signed [25:0]  vdiff;
    logic signed [34:0]  w_wide;
    logic signed [31:0]  w_sat;
    logic [41:0]         bam42;
    logic [25:0]         vx_mag;
    logic [25:0]         vy_mag;
    logic signed [25:0]  vx_db;
    logic signed [25:0]  vy_db;

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .angle  (heading_acc_reg),
        .result (cs)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_CORDIC;
            ST_CORDIC: if (cs.done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_WB;
            ST_WB:     state_next = (op_reg == OP_V_SDT) ? ST_DONE : ST_MUL;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_LEFT_WR:
            begin
                mul_a = {{17{left_reg[15]}}, left_reg};
                mul_b = {17'b0, wheel_radius_reg};
            end
            OP_RIGHT_WR:
            begin
                mul_a = {{17{right_reg[15]}}, right_reg};
                mul_b = {17'b0, wheel_radius_reg};
            end
            OP_DIFF_IB:
            begin
                mul_a = {{7{diff_reg[25]}}, diff_reg};
                mul_b = {17'b0, inverse_wheelbase_reg};
            end
            OP_HS_DT:
            begin
                mul_a = {17'b0, heading_scale_reg};
                mul_b = {17'b0, dt_reg};
            end
            OP_W_HSDT:
            begin
                mul_a = {w_reg[31], w_reg};
                mul_b = {1'b0, hsdt_reg};
            end
            OP_RADH_K:
            begin
                mul_a = {{10{rad_reg[38]}}, rad_reg[38:16]};
                mul_b = {9'b0, RAD_TO_BAM_Q10};
            end
            OP_RADL_K:
            begin
                mul_a = {17'b0, rad_reg[15:0]};
                mul_b = {9'b0, RAD_TO_BAM_Q10};
            end
            OP_V_C:
            begin
                mul_a = {{8{v_reg[24]}}, v_reg};
                mul_b = {{16{cs.cos_val[16]}}, cs.cos_val};
            end
            OP_V_S:
            begin
                mul_a = {{8{v_reg[24]}}, v_reg};
                mul_b = {{16{cs.sin_val[16]}}, cs.sin_val};
            end
            OP_C_DT:
            begin
                mul_a = {{16{cs.cos_val[16]}}, cs.cos_val};
                mul_b = {17'b0, dt_reg};
            end
            OP_S_DT:
            begin
                mul_a = {{16{cs.sin_val[16]}}, cs.sin_val};
                mul_b = {17'b0, dt_reg};
            end
            OP_V_CDT, OP_V_SDT:
            begin
                mul_a = {{8{v_reg[24]}}, v_reg};
                mul_b = tdt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign prod_q8 = prod_reg[32:8];
    assign vsum    = {vl_reg[24], vl_reg} + {prod_q8[24], prod_q8};
    assign vdiff   = {prod_q8[24], prod_q8} - {vl_reg[24], vl_reg};
    assign w_wide  = prod_reg[42:8];
    assign bam42   = {bamh_reg, 16'h0000} + prod_reg[41:0];

    always_comb
    begin
        if (w_wide[34:31] == {4{w_wide[31]}})
            w_sat = w_wide[31:0];
        else if (w_wide[34])
            w_sat = 32'sh8000_0000;
        else
            w_sat = 32'sh7FFF_FFFF;
    end

    assign vx_mag = vx_reg[25] ? 26'(-vx_reg) : vx_reg;
    assign vy_mag = vy_reg[25] ? 26'(-vy_reg) : vy_reg;
    assign vx_db  = (vx_mag < {10'b0, speed_deadband_reg}) ? 26'sd0 : vx_reg;
    assign vy_db  = (vy_mag < {10'b0, speed_deadband_reg}) ? 26'sd0 : vy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            op_reg                <= OP_LEFT_WR;
            out_valid_reg         <= 1'b0;
            wheel_radius_reg      <= 16'd5603;
            inverse_wheelbase_reg <= 16'd1344;
            heading_scale_reg     <= 16'd16384;
            speed_deadband_reg    <= 16'd59;
            pos_x_reg             <= '0;
            pos_y_reg             <= '0;
            heading_acc_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept)
                op_reg <= OP_LEFT_WR;
            else if ((state_reg == ST_WB) && (op_reg != OP_V_SDT))
                op_reg <= op_t'(op_reg + 4'd1);

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_WHEEL_RADIUS:      wheel_radius_reg      <= cfg_data;
                    REG_INVERSE_WHEELBASE: inverse_wheelbase_reg <= cfg_data;
                    REG_HEADING_SCALE:     heading_scale_reg     <= cfg_data;
                    REG_SPEED_DEADBAND:    speed_deadband_reg    <= cfg_data;
                    default:               ;
                endcase
            end

            if (state_reg == ST_WB)
            begin
                unique case (op_reg)
                    OP_RADL_K: heading_acc_reg <= heading_acc_reg + bam42[41:10];
                    OP_V_CDT:  pos_x_reg <= pos_x_reg + prod_reg[56:25];
                    OP_V_SDT:  pos_y_reg <= pos_y_reg + prod_reg[56:25];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_reg  <= left_wheel_speed;
            right_reg <= right_wheel_speed;
            dt_reg    <= elapsed_time;
        end

        if (state_reg == ST_MUL)
            prod_reg <= mul_p;

        if (state_reg == ST_WB)
        begin
            unique case (op_reg)
                OP_LEFT_WR:  vl_reg <= prod_q8;
                OP_RIGHT_WR:
                begin
                    v_reg    <= vsum[25:1];
                    diff_reg <= vdiff;
                end
                OP_DIFF_IB:  w_reg    <= w_sat;
                OP_HS_DT:    hsdt_reg <= prod_reg[31:0];
                OP_W_HSDT:   rad_reg  <= prod_reg[63:25];
                OP_RADH_K:   bamh_reg <= prod_reg[25:0];
                OP_V_C:      vx_reg   <= prod_reg[40:15];
                OP_V_S:      vy_reg   <= prod_reg[40:15];
                OP_C_DT:     tdt_reg  <= prod_reg[32:0];
                OP_S_DT:     tdt_reg  <= prod_reg[32:0];
                default:     ;
            endcase
        end

        if (out_load)
        begin
            x_position_reg    <= pos_x_reg;
            y_position_reg    <= pos_y_reg;
            heading_angle_reg <= heading_acc_reg[31:16];
            vel_x_reg         <= {{6{vx_db[25]}}, vx_db};
            vel_y_reg         <= {{6{vy_db[25]}}, vy_db};
            turn_rate_reg     <= w_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign x_position    = x_position_reg;
    assign y_position    = y_position_reg;
    assign heading_angle = heading_angle_reg;
    assign vel_x         = vel_x_reg;
    assign vel_y         = vel_y_reg;
    assign turn_rate     = turn_rate_reg;

endmodule

// File: rtl/ddo_checker.sv
// Port-level checker for the odometry block and its bind to the top level.
module ddo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] x_position,
    input logic signed [31:0] y_position,
    input logic [15:0]        heading_angle
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_position)
            && $stable(y_position) && $stable(heading_angle))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after input transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded while still busy");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .x_position    (x_position),
    .y_position    (y_position),
    .heading_angle (heading_angle)
);

// File: test/tb_differential_drive_odometry.sv
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_odometry: predicts pose and velocity per transaction.
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] w;
    } pose_t;

    localparam int     ROTATIONS = 16;
    localparam longint TURN_MAX  = 64'sd2147483647;
    localparam longint TURN_MIN  = -64'sd2147483648;

    longint arc_step [24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
    };

    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   in_valid          = 1'b0;
    logic                   in_ready;
    logic signed [15:0]     left_wheel_speed  = '0;
    logic signed [15:0]     right_wheel_speed = '0;
    logic [15:0]            elapsed_time      = '0;
    logic                   out_valid;
    logic                   out_ready         = 1'b0;
    logic signed [31:0]     x_position;
    logic signed [31:0]     y_position;
    logic [15:0]            heading_angle;
    logic signed [31:0]     vel_x;
    logic signed [31:0]     vel_y;
    logic signed [31:0]     turn_rate;
    logic                   cfg_write_en      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index         = '0;
    logic [CFG_W-1:0]       cfg_data          = '0;

    logic [15:0] radius_q16   = 16'd5603;
    logic [15:0] base_inv_q8  = 16'd1344;
    logic [15:0] hdg_gain_q15 = 16'd16384;
    logic [15:0] db_q16       = 16'd59;
    logic [31:0] pose_x       = '0;
    logic [31:0] pose_y       = '0;
    logic [31:0] heading_bam  = '0;

    pose_t pending_poses [$];
    pose_t want;
    int    mismatch_count    = 0;
    int    ready_hold_cycles = 0;
    bit    steady_flow       = 1'b0;

    differential_drive_odometry uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint q15_round(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint apply_deadband(input longint v);
        longint band;
        band = db_q16;
        if ((v < 0 ? -v : v) < band)
            return 0;
        return v;
    endfunction

    function automatic pose_t advance_pose(input logic signed [15:0] lspd,
                                           input logic signed [15:0] rspd,
                                           input logic [15:0] dt_raw);
        longint ls, rs, dt, rq, iq, hq, vl, vr, v, w;
        longint cx, cy, nx, z, cq, sq, c, s, pc, ps, step, rad, bam;
        logic [31:0] folded;
        pose_t p;
        int i;
        ls = lspd;
        rs = rspd;
        dt = dt_raw;
        rq = radius_q16;
        iq = base_inv_q8;
        hq = hdg_gain_q15;
        vl = (ls * rq) >>> 8;
        vr = (rs * rq) >>> 8;
        v = (vl + vr) >>> 1;
        w = ((vr - vl) * iq) >>> 8;
        if (w > TURN_MAX)
            w = TURN_MAX;
        if (w < TURN_MIN)
            w = TURN_MIN;

        // fold into one quadrant centered on zero, rotate, then unfold
        folded = heading_bam + 32'h2000_0000;
        z = folded[29:0];
        z = z - 536870912;
        cx = 652032875;
        cy = 0;
        for (i = 0; i < ROTATIONS; i++)
        begin
            if (z >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z = z - arc_step[i];
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z = z + arc_step[i];
            end
            cx = nx;
        end
        cq = q15_round(cx);
        sq = q15_round(cy);
        case (folded[31:30])
            2'd0:
            begin
                c = cq;
                s = sq;
            end
            2'd1:
            begin
                c = -sq;
                s = cq;
            end
            2'd2:
            begin
                c = -cq;
                s = -sq;
            end
            default:
            begin
                c = sq;
                s = -cq;
            end
        endcase

        pc = v * c;
        ps = v * s;
        step = (pc * dt) >>> 25;
        pose_x = pose_x + step[31:0];
        step = (ps * dt) >>> 25;
        pose_y = pose_y + step[31:0];
        rad = (w * hq * dt) >>> 25;
        bam = (rad * 10680707) >>> 10;
        heading_bam = heading_bam + bam[31:0];

        p.x = pose_x;
        p.y = pose_y;
        p.heading = heading_bam[31:16];
        step = apply_deadband(pc >>> 15);
        p.vx = step[31:0];
        step = apply_deadband(ps >>> 15);
        p.vy = step[31:0];
        p.w = w[31:0];
        return p;
    endfunction

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return 16'($urandom_range(0, 128) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want_val);
        if (mismatch_count < 100)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want_val, $time);
        mismatch_count++;
    endtask

    task automatic drive_wheels(input logic signed [15:0] lspd, input logic signed [15:0] rspd,
                                input logic [15:0] dt_raw);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        left_wheel_speed  <= lspd;
        right_wheel_speed <= rspd;
        elapsed_time      <= dt_raw;
        do @(posedge clk); while (!in_ready);
        pending_poses.push_back(advance_pose(lspd, rspd, dt_raw));
    endtask

    task automatic drive_random();
        logic signed [15:0] lspd, rspd;
        logic [15:0] dt_raw;
        lspd = pick_speed();
        case ($urandom_range(0, 5))
            0: rspd = lspd;
            1: rspd = -lspd;
            default: rspd = pick_speed();
        endcase
        case ($urandom_range(0, 9))
            0: dt_raw = 16'd0;
            1: dt_raw = 16'hFFFF;
            2, 3, 4, 5: dt_raw = 16'($urandom_range(1, 255));
            default: dt_raw = 16'($urandom);
        endcase
        drive_wheels(lspd, rspd, dt_raw);
    endtask

    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WHEEL_RADIUS:      radius_q16   = val;
            REG_INVERSE_WHEELBASE: base_inv_q8  = val;
            REG_HEADING_SCALE:     hdg_gain_q15 = val;
            REG_SPEED_DEADBAND:    db_q16       = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] radius, input logic [15:0] inv_base,
                                input logic [15:0] gain, input logic [15:0] band);
        write_reg(REG_WHEEL_RADIUS, radius);
        write_reg(REG_INVERSE_WHEELBASE, inv_base);
        write_reg(REG_HEADING_SCALE, gain);
        write_reg(REG_SPEED_DEADBAND, band);
    endtask

    task automatic run_default_checks();
        drive_wheels(16'sd0, 16'sd0, 16'd0);
        drive_wheels(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        drive_wheels(16'sh8000, 16'sh8000, 16'hFFFF);
        drive_wheels(16'sd1, 16'sd1, 16'd100);
        drive_wheels(-16'sd1, -16'sd1, 16'd100);
        drive_wheels(16'sh7FFF, 16'sh8000, 16'hFFFF);
        drive_wheels(16'sh8000, 16'sh7FFF, 16'hFFFF);
        drive_wheels(16'sd500, 16'sd300, 16'd0);
        drive_wheels(16'sd1000, -16'sd1000, 16'd4000);
        drive_wheels(16'sd3000, 16'sd3000, 16'd1024);
        drive_wheels(-16'sd1, 16'sd1, 16'hFFFF);
        drive_wheels(16'sd2, 16'sd1, 16'd7);
        settle_results();
    endtask

    task automatic run_register_extremes();
        logic [CFG_IDX_W-1:0] spare_idx;
        logic [15:0] spare_val;
        // widest wheel and largest inverse wheelbase: turn rate saturates, positions wrap
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        drive_wheels(16'sh7FFF, 16'sh8000, 16'hFFFF);
        drive_wheels(16'sh8000, 16'sh7FFF, 16'hFFFF);
        repeat (4) drive_wheels(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        drive_wheels(16'sh7FFF, 16'sh7FFF, 16'h0000);
        settle_results();
        spare_idx = CFG_IDX_W'($urandom_range(4, 15));
        spare_val = 16'($urandom);
        write_reg(spare_idx, spare_val);
        drive_wheels(16'sd100, 16'sd50, 16'd1000);
        drive_wheels(-16'sd20000, 16'sd12000, 16'd3000);
        settle_results();
        apply_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        drive_wheels(16'sh7FFF, 16'sh8000, 16'hFFFF);
        drive_wheels(16'sh8000, 16'sh8000, 16'hFFFF);
        settle_results();
    endtask

    task automatic run_backpressure();
        apply_config(16'd5603, 16'd1344, 16'd16384, 16'd59);
        steady_flow = 1'b1;
        ready_hold_cycles = 400;
        repeat (12) drive_random();
        // hold the sender until every result is back
        settle_results();
        repeat (6) drive_random();
        settle_results();
        steady_flow = 1'b0;
    endtask

    task automatic run_random_drive();
        int ph, k;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_config(16'($urandom_range(1000, 12000)),
                                16'($urandom_range(256, 4096)),
                                16'($urandom), 16'($urandom_range(0, 500)));
                1: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 300)));
                2: apply_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
                3: apply_config(16'($urandom), 16'h0000, 16'hFFFF, 16'hFFFF);
                default: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'(($urandom_range(0, 3) == 0) ? $urandom
                                                                      : $urandom_range(0, 1000)));
            endcase
            for (k = 0; k < 210; k++)
            begin
                if (k % 50 == 0)
                    steady_flow = ($urandom_range(0, 3) == 0);
                drive_random();
            end
            settle_results();
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (ready_hold_cycles > 0)
            begin
                gap = ready_hold_cycles;
                ready_hold_cycles = 0;
            end
            else
            begin
                gap = steady_flow ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                report_mismatch("result with nothing pending", x_position, '0);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (x_position !== want.x)
                    report_mismatch("x_position", x_position, want.x);
                if (y_position !== want.y)
                    report_mismatch("y_position", y_position, want.y);
                if (heading_angle !== want.heading)
                    report_mismatch("heading_angle", {16'd0, heading_angle}, {16'd0, want.heading});
                if (vel_x !== want.vx)
                    report_mismatch("vel_x", vel_x, want.vx);
                if (vel_y !== want.vy)
                    report_mismatch("vel_y", vel_y, want.vy);
                if (turn_rate !== want.w)
                    report_mismatch("turn_rate", turn_rate, want.w);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_default_checks();
        run_register_extremes();
        run_backpressure();
        run_random_drive();
        settle_results();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
